// File: sv/assert_macros.svh
// assertion helpers used by the sketch rtl
// each macro expects clk and rst to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define KQS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define KQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/kqs_pkg.sv
// ----------------------------------------------------------------------------
// kqs_pkg
// Shared constants, codes and the lfsr helper function of the quantile sketch.
// ----------------------------------------------------------------------------
package kqs_pkg;

  // default sizes
  localparam int DEF_MAX_LEVELS   = 16;
  localparam int DEF_MAX_CAPACITY = 256;
  localparam int DEF_VALUE_BITS   = 31;

  // field widths
  localparam int OP_W       = 2;
  localparam int Q_W        = 16;
  localparam int ANSWER_W   = 48;
  localparam int TOPCAP_W   = 9;
  localparam int SEED_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int NORM_W     = 64;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_RANK     = 2'd1;
  localparam logic [OP_W-1:0] OP_QUANTILE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_SEED     = 2'd2;

  // reset values of the registers
  localparam logic [TOPCAP_W-1:0] RST_TOP_CAPACITY  = 9'd128;
  localparam logic [Q_W-1:0]      RST_SHRINK_FACTOR = 16'd43691;
  localparam logic [SEED_W-1:0]   RST_COIN_SEED     = 32'd1;

  // fixed point rounding constant for Q0.16
  localparam logic [Q_W-1:0] Q_HALF = 16'h8000;

  // coin generator taps and sqrt(2) mantissa for the pass count
  localparam logic [SEED_W-1:0] LFSR_TAPS  = 32'h8020_0003;
  localparam logic [NORM_W-1:0] SQRT2_MANT = 64'hB504_F333_F9DE_6485;

  // galois lfsr, shifting right
  function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] r;
    r = {1'b0, s[SEED_W-1:1]};
    if (s[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

endpackage

// File: sv/kqs_ram.sv
// ----------------------------------------------------------------------------
// kqs_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module kqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/kqs_cap.sv
// ----------------------------------------------------------------------------
// kqs_cap
// Level capacity table: one fixed point multiply per cycle builds
// cap(depth) for every depth, then the table is read by depth.
// ----------------------------------------------------------------------------
module kqs_cap
  import kqs_pkg::*;
#(
  parameter int MAX_LEVELS   = DEF_MAX_LEVELS,
  parameter int MAX_CAPACITY = DEF_MAX_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [TOPCAP_W-1:0]                 top_capacity,
  input  logic [Q_W-1:0]                      shrink_factor,
  input  logic [$clog2(MAX_LEVELS)-1:0]       rd_depth,
  output logic                                done,
  output logic [$clog2(MAX_CAPACITY+1)-1:0]   rd_cap
);

  localparam int LVL_W  = $clog2(MAX_LEVELS);
  localparam int FILL_W = $clog2(MAX_CAPACITY + 1);
  localparam int ACC_W  = FILL_W + Q_W;
  localparam int PROD_W = ACC_W + Q_W;

  logic [FILL_W-1:0] caps [MAX_LEVELS];
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_next;
  logic [PROD_W-1:0] prod;
  logic [FILL_W:0]   cap_round;
  logic [FILL_W-1:0] cap_val;
  logic [FILL_W-1:0] k_clamped;
  logic [LVL_W-1:0]  cnt;
  logic              busy;

  // top capacity clamped to the storage limit
  assign k_clamped = (int'(top_capacity) > MAX_CAPACITY) ? FILL_W'(MAX_CAPACITY)
                                                          : FILL_W'(top_capacity);

  // acc * c rounded back to the accumulator scale
  assign prod     = PROD_W'(acc) * PROD_W'(shrink_factor);
  assign acc_next = ACC_W'((prod + PROD_W'(Q_HALF)) >> Q_W);

  // capacity of the current depth, at least two
  assign cap_round = (FILL_W + 1)'((({1'b0, acc}) + (ACC_W + 1)'(Q_HALF)) >> Q_W);
  assign cap_val   = (cap_round < (FILL_W + 1)'(2)) ? FILL_W'(2) : FILL_W'(cap_round);

  // table sweep, one depth per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= {k_clamped, Q_W'(0)};
      end else if (busy) begin
        caps[cnt] <= cap_val;
        acc       <= acc_next;
        if (cnt == LVL_W'(MAX_LEVELS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign rd_cap = caps[rd_depth];

endmodule

// File: sv/kll_quantile_sketch.sv
// ----------------------------------------------------------------------------
// kll_quantile_sketch
// Streaming quantile sketch made of sorted compactor levels held in one
// memory, answering inserts, rank queries and quantile queries one word at a
// time. An insert builds the capacity table, runs a room check over the
// levels, shifts each level 0 entry above the new value up by one place, and
// then writes each entry of every compaction merge. A rank query reads every
// stored entry of every level, and a quantile query runs up to VALUE_BITS + 1
// rank scans after a setup that normalises the largest value and forms the
// target rank. This step by step work is set by the single read port of the
// level memory. A new word is taken whenever the sequencer is idle,
// even while the previous result still waits on the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kll_quantile_sketch
  import kqs_pkg::*;
#(
  parameter int MAX_LEVELS   = DEF_MAX_LEVELS,
  parameter int MAX_CAPACITY = DEF_MAX_CAPACITY,
  parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       op,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [Q_W-1:0]        fraction,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ANSWER_W-1:0]   answer,
  output logic                  status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LVL_W     = $clog2(MAX_LEVELS);
  localparam int IDX_W     = $clog2(MAX_CAPACITY);
  localparam int FILL_W    = $clog2(MAX_CAPACITY + 1);
  localparam int ADDR_W    = LVL_W + IDX_W;
  localparam int MEM_DEPTH = MAX_LEVELS * (2 ** IDX_W);
  localparam int NK_W      = 6;
  localparam int PASS_W    = 7;
  localparam int PLO_W     = 24 + Q_W;

  typedef enum logic [18:0] {
    S_IDLE    = 19'h00001,
    S_CAP     = 19'h00002,
    S_PRE     = 19'h00004,
    S_INS_RD  = 19'h00008,
    S_INS_CMP = 19'h00010,
    S_CHK     = 19'h00020,
    S_M_A     = 19'h00040,
    S_M_B     = 19'h00080,
    S_M_C     = 19'h00100,
    S_M_OUT   = 19'h00200,
    S_M_CAP   = 19'h00400,
    S_RANK    = 19'h00800,
    S_Q_NORM  = 19'h01000,
    S_Q_MUL1  = 19'h02000,
    S_Q_MUL2  = 19'h04000,
    S_Q_TGT   = 19'h08000,
    S_Q_STEP  = 19'h10000,
    S_Q_UPD   = 19'h20000,
    S_DONE    = 19'h40000
  } state_t;

  state_t state;

  // configuration and sketch state
  logic [TOPCAP_W-1:0]   top_capacity;
  logic [Q_W-1:0]        shrink_factor;
  logic [SEED_W-1:0]     coin_lfsr;
  logic [FILL_W-1:0]     level_fill [MAX_LEVELS];
  logic [LVL_W-1:0]      top_level;
  logic [ANSWER_W-1:0]   items_seen;
  logic [VALUE_BITS-1:0] largest_value;
  logic                  full_flag;

  // current word
  logic [VALUE_BITS-1:0] val_r;
  logic [Q_W-1:0]        frac_r;
  logic [ANSWER_W-1:0]   res_answer;
  logic                  res_status;

  // compaction walk
  logic [LVL_W-1:0]  wl;
  logic [LVL_W-1:0]  wh;
  logic [SEED_W-1:0] ws;
  logic [FILL_W-1:0] wn;
  logic [FILL_W-1:0] ins_n;
  logic [IDX_W-1:0]  ii;

  // merge engine
  logic [LVL_W-1:0]      m_lvl;
  logic                  mstart;
  logic [FILL_W-1:0]     a_cnt;
  logic [FILL_W-1:0]     b_cnt;
  logic [IDX_W-1:0]      mo;
  logic [VALUE_BITS-1:0] a_val;
  logic [VALUE_BITS-1:0] b_val;
  logic                  took_b;

  // rank scan
  logic [LVL_W:0]        rl;
  logic [FILL_W-1:0]     rj;
  logic                  pv;
  logic [LVL_W-1:0]      plev;
  logic [VALUE_BITS-1:0] rank_x;
  logic [ANSWER_W-1:0]   rsum;
  logic                  qmode;

  // quantile search
  logic [NORM_W-1:0]     nv;
  logic [NK_W-1:0]       nk;
  logic [PASS_W-1:0]     passes;
  logic [PASS_W-1:0]     pcnt;
  logic [PLO_W-1:0]      plo;
  logic [PLO_W-1:0]      phi;
  logic [ANSWER_W-1:0]   target;
  logic [ANSWER_W-1:0]   qr;
  logic [VALUE_BITS-1:0] qlo;
  logic [VALUE_BITS-1:0] qhi;
  logic [VALUE_BITS-1:0] qx;

  // combinational helpers
  logic                  accept;
  logic                  cfg_write;
  logic                  cap_start;
  logic                  cap_done;
  logic [FILL_W-1:0]     cap_rd;
  logic [LVL_W-1:0]      fidx;
  logic [FILL_W-1:0]     fill_rd;
  logic [SEED_W-1:0]     s_nx;
  logic                  st;
  logic [FILL_W-1:0]     kept;
  logic [FILL_W:0]       sum_nx;
  logic [FILL_W:0]       n_next;
  logic                  stop;
  logic                  new_top;
  logic                  no_room;
  logic                  take_b;
  logic                  merge_last;
  logic                  rank_done;
  logic                  out_free;
  logic [LVL_W-1:0]      dst_lvl;
  logic [FILL_W:0]       b_pos1;
  logic [FILL_W:0]       b_pos2;
  logic [ANSWER_W+Q_W-1:0] tsum;
  logic                  q_gt;
  logic [VALUE_BITS-1:0] qlo_n;
  logic [VALUE_BITS-1:0] qhi_n;
  logic [VALUE_BITS:0]   qmid;

  // memory port
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;

  // handshakes
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = (state == S_IDLE);
  assign cfg_write = cfg_valid && cfg_ready;
  assign cap_start = accept && (op == OP_INSERT) && !full_flag;
  assign out_free  = !out_valid || !out_stall;

  // level memory
  kqs_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // capacity table
  kqs_cap #(
    .MAX_LEVELS   (MAX_LEVELS),
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_cap (
    .clk           (clk),
    .rst           (rst),
    .start         (cap_start),
    .top_capacity  (top_capacity),
    .shrink_factor (shrink_factor),
    .rd_depth      (wh - wl),
    .done          (cap_done),
    .rd_cap        (cap_rd)
  );

  // single read index into the fill counters
  always_comb begin
    if (state == S_RANK) begin
      fidx = rl[LVL_W-1:0];
    end else if (state == S_CAP) begin
      fidx = '0;
    end else begin
      fidx = wl + 1'b1;
    end
  end
  assign fill_rd = level_fill[fidx];

  // one compaction step of the walk
  assign s_nx    = lfsr_next(ws);
  assign st      = s_nx[SEED_W-1];
  assign kept    = FILL_W'(((FILL_W + 1)'(wn) + (FILL_W + 1)'(1) - (FILL_W + 1)'(st)) >> 1);
  assign sum_nx  = (FILL_W + 1)'(fill_rd) + (FILL_W + 1)'(kept);
  assign new_top = (wl == wh);
  assign n_next  = new_top ? (FILL_W + 1)'(kept) : sum_nx;
  assign stop    = (wn < cap_rd);
  assign no_room = new_top ? (int'(wh) >= MAX_LEVELS - 1)
                           : (int'(sum_nx) > MAX_CAPACITY);

  // merge helpers, filling the destination from its top end
  assign dst_lvl    = m_lvl + 1'b1;
  assign take_b     = (b_cnt != '0) && ((a_cnt == '0) || (b_val >= a_val));
  assign merge_last = ((FILL_W + 1)'(a_cnt) + (FILL_W + 1)'(b_cnt)) == (FILL_W + 1)'(1);
  assign b_pos1     = {FILL_W'(b_cnt - 1'b1), mstart};
  assign b_pos2     = {FILL_W'(b_cnt - 2'd2), mstart};

  // rank scan end
  assign rank_done = (rl > {1'b0, top_level});

  // quantile helpers
  assign tsum  = ((ANSWER_W + Q_W)'(phi) << 24) + (ANSWER_W + Q_W)'(plo)
               + (ANSWER_W + Q_W)'(Q_HALF);
  assign q_gt  = (rsum > target);
  assign qlo_n = q_gt ? qlo : qx;
  assign qhi_n = q_gt ? qx : qhi;
  assign qmid  = ((VALUE_BITS + 1)'(qlo_n) + (VALUE_BITS + 1)'(qhi_n)) >> 1;

  // memory address and data selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = val_r;
    mem_raddr = '0;
    unique case (state)
      S_INS_RD: begin
        if (ii == '0) begin
          mem_we    = 1'b1;
          mem_waddr = {LVL_W'(0), IDX_W'(0)};
          mem_wdata = val_r;
        end else begin
          mem_raddr = {LVL_W'(0), IDX_W'(ii - 1'b1)};
        end
      end
      S_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = {LVL_W'(0), ii};
        mem_wdata = (mem_rdata > val_r) ? mem_rdata : val_r;
      end
      S_M_A: begin
        mem_raddr = {dst_lvl, IDX_W'(a_cnt - 1'b1)};
      end
      S_M_B: begin
        mem_raddr = {m_lvl, b_pos1[IDX_W-1:0]};
      end
      S_M_OUT: begin
        mem_we    = 1'b1;
        mem_waddr = {dst_lvl, mo};
        mem_wdata = take_b ? b_val : a_val;
        if (take_b) begin
          mem_raddr = {m_lvl, b_pos2[IDX_W-1:0]};
        end else begin
          mem_raddr = {dst_lvl, IDX_W'(a_cnt - 2'd2)};
        end
      end
      S_RANK: begin
        mem_raddr = {rl[LVL_W-1:0], rj[IDX_W-1:0]};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      top_capacity  <= RST_TOP_CAPACITY;
      shrink_factor <= RST_SHRINK_FACTOR;
      coin_lfsr     <= RST_COIN_SEED;
      top_level     <= '0;
      items_seen    <= '0;
      largest_value <= '0;
      full_flag     <= 1'b0;
      pv            <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        level_fill[i] <= '0;
      end
    end else begin
      pv <= 1'b0;
      // rank accumulation in the cycle after the read
      if (pv && (mem_rdata < rank_x)) begin
        rsum <= rsum + (ANSWER_W'(1) << plev);
      end

      // register writes
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_TOP_CAPACITY:  top_capacity  <= cfg_data[TOPCAP_W-1:0];
          CFG_SHRINK_FACTOR: shrink_factor <= cfg_data[Q_W-1:0];
          CFG_COIN_SEED: begin
            coin_lfsr <= (cfg_data == '0) ? RST_COIN_SEED : cfg_data;
          end
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            val_r      <= value;
            frac_r     <= fraction;
            res_answer <= '0;
            res_status <= 1'b0;
            unique case (op)
              OP_INSERT: begin
                if (full_flag) begin
                  res_status <= 1'b1;
                  state      <= S_DONE;
                end else begin
                  state <= S_CAP;
                end
              end
              OP_RANK: begin
                rank_x <= value;
                rl     <= '0;
                rj     <= '0;
                rsum   <= '0;
                qmode  <= 1'b0;
                state  <= S_RANK;
              end
              OP_QUANTILE: begin
                if (largest_value == '0) begin
                  state <= S_DONE;
                end else begin
                  nv    <= NORM_W'(largest_value) << (NORM_W - VALUE_BITS);
                  nk    <= NK_W'(VALUE_BITS - 1);
                  state <= S_Q_NORM;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end

        // wait for the capacity table, then check level 0 room
        S_CAP: begin
          if (cap_done) begin
            ins_n <= fill_rd;
            if (int'(fill_rd) >= MAX_CAPACITY) begin
              full_flag  <= 1'b1;
              res_status <= 1'b1;
              state      <= S_DONE;
            end else begin
              wl    <= '0;
              wh    <= top_level;
              ws    <= coin_lfsr;
              wn    <= fill_rd + 1'b1;
              state <= S_PRE;
            end
          end
        end

        // dry run of the compaction on counts only
        S_PRE: begin
          if (stop) begin
            ii            <= IDX_W'(ins_n);
            wl            <= '0;
            wh            <= top_level;
            ws            <= coin_lfsr;
            wn            <= ins_n + 1'b1;
            items_seen    <= items_seen + 1'b1;
            largest_value <= (val_r > largest_value) ? val_r : largest_value;
            state         <= S_INS_RD;
          end else if (no_room) begin
            full_flag  <= 1'b1;
            res_status <= 1'b1;
            state      <= S_DONE;
          end else begin
            ws <= s_nx;
            wl <= wl + 1'b1;
            wh <= new_top ? wh + 1'b1 : wh;
            wn <= FILL_W'(n_next);
          end
        end

        // sorted insert into level 0, shifting larger entries up
        S_INS_RD: begin
          if (ii == '0) begin
            state <= S_CHK;
          end else begin
            state <= S_INS_CMP;
          end
        end

        S_INS_CMP: begin
          if (mem_rdata > val_r) begin
            ii    <= ii - 1'b1;
            state <= S_INS_RD;
          end else begin
            state <= S_CHK;
          end
        end

        // committed compaction walk
        S_CHK: begin
          if (stop) begin
            level_fill[wl] <= wn;
            top_level      <= wh;
            coin_lfsr      <= ws;
            state          <= S_DONE;
          end else begin
            level_fill[wl] <= '0;
            m_lvl          <= wl;
            mstart         <= st;
            a_cnt          <= new_top ? '0 : fill_rd;
            b_cnt          <= kept;
            mo             <= IDX_W'(n_next - 1'b1);
            ws             <= s_nx;
            wl             <= wl + 1'b1;
            wh             <= new_top ? wh + 1'b1 : wh;
            wn             <= FILL_W'(n_next);
            state          <= S_M_A;
          end
        end

        // load both list heads
        S_M_A: state <= S_M_B;

        S_M_B: begin
          a_val <= mem_rdata;
          state <= S_M_C;
        end

        S_M_C: begin
          b_val <= mem_rdata;
          state <= S_M_OUT;
        end

        // write the larger head, fetch its successor
        S_M_OUT: begin
          took_b <= take_b;
          if (take_b) begin
            b_cnt <= b_cnt - 1'b1;
          end else begin
            a_cnt <= a_cnt - 1'b1;
          end
          if (merge_last) begin
            state <= S_CHK;
          end else begin
            mo    <= mo - 1'b1;
            state <= S_M_CAP;
          end
        end

        S_M_CAP: begin
          if (took_b) begin
            b_val <= mem_rdata;
          end else begin
            a_val <= mem_rdata;
          end
          state <= S_M_OUT;
        end

        // rank scan over all filled entries
        S_RANK: begin
          if (rank_done) begin
            if (qmode) begin
              state <= S_Q_UPD;
            end else begin
              res_answer <= rsum;
              state      <= S_DONE;
            end
          end else if (rj < fill_rd) begin
            pv   <= 1'b1;
            plev <= rl[LVL_W-1:0];
            rj   <= rj + 1'b1;
          end else begin
            rl <= rl + 1'b1;
            rj <= '0;
          end
        end

        // find the leading one of the largest value
        S_Q_NORM: begin
          if (nv[NORM_W-1]) begin
            passes <= PASS_W'(nk) + PASS_W'(1) + PASS_W'(nv >= SQRT2_MANT);
            state  <= S_Q_MUL1;
          end else begin
            nv <= nv << 1;
            nk <= nk - 1'b1;
          end
        end

        // target rank in two partial products
        S_Q_MUL1: begin
          plo   <= PLO_W'(items_seen[23:0]) * PLO_W'(frac_r);
          state <= S_Q_MUL2;
        end

        S_Q_MUL2: begin
          phi   <= PLO_W'(items_seen[ANSWER_W-1:24]) * PLO_W'(frac_r);
          state <= S_Q_TGT;
        end

        S_Q_TGT: begin
          target <= tsum[ANSWER_W+Q_W-1:Q_W];
          qlo    <= '0;
          qhi    <= largest_value;
          qx     <= largest_value >> 1;
          qr     <= '0;
          pcnt   <= '0;
          state  <= S_Q_STEP;
        end

        // binary search pass
        S_Q_STEP: begin
          if ((pcnt == passes) || (qr == target)) begin
            res_answer <= ANSWER_W'(qx);
            state      <= S_DONE;
          end else begin
            rank_x <= qx;
            rl     <= '0;
            rj     <= '0;
            rsum   <= '0;
            qmode  <= 1'b1;
            state  <= S_RANK;
          end
        end

        S_Q_UPD: begin
          qr    <= rsum;
          qlo   <= qlo_n;
          qhi   <= qhi_n;
          qx    <= VALUE_BITS'(qmid);
          pcnt  <= pcnt + 1'b1;
          state <= S_Q_STEP;
        end

        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
      answer    <= res_answer;
      status    <= res_status;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  `KQS_ASSERT_ALWAYS(a_lfsr_nonzero, coin_lfsr != '0, "coin lfsr reached zero")
  `KQS_ASSERT_NEXT(a_full_sticky, full_flag, full_flag, "full flag cleared without reset")
  `KQS_ASSERT_ALWAYS(a_fill0_bound, int'(level_fill[0]) <= MAX_CAPACITY, "level 0 overfilled")

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quantile sketch. Words go in with random gaps,
// results come out under random stalls. A behavioral copy of the sketch
// (sorted levels, coin lfsr, fixed point capacities, rank and quantile search)
// runs at each accepted word and its answers are compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import kqs_pkg::*;

  localparam int LEVELS   = DEF_MAX_LEVELS;
  localparam int CAPACITY = DEF_MAX_CAPACITY;
  localparam int VBITS    = DEF_VALUE_BITS;
  localparam int CYCLE_LIMIT = 100_000_000;
  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [ANSWER_W-1:0] answer;
    logic                status;
  } sketch_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       op = OP_INSERT;
  logic [VBITS-1:0]      value = '0;
  logic [Q_W-1:0]        fraction = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ANSWER_W-1:0]   answer;
  logic                  status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  kll_quantile_sketch u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .value(value), .fraction(fraction),
    .out_valid(out_valid), .out_stall(out_stall),
    .answer(answer), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // sketch copy used for prediction
  logic [VBITS-1:0]    lvl_mem [LEVELS*CAPACITY];
  int unsigned         lvl_fill [LEVELS];
  int unsigned         lvl_top;
  logic [ANSWER_W-1:0] n_items;
  logic [VBITS-1:0]    max_seen;
  logic [SEED_W-1:0]   coin;
  bit                  is_full;
  logic [TOPCAP_W-1:0] k_reg;
  logic [Q_W-1:0]      c_reg;

  sketch_result_t expected_q[$];
  int  errors;
  bit  no_idle;
  int  hold_cnt;
  longint cycles;

  // level capacity for a given depth below the top
  function automatic int unsigned cap_at(int unsigned depth);
    logic [63:0] acc;
    acc = (k_reg > CAPACITY ? 64'(CAPACITY) : 64'(k_reg)) << 16;
    for (int i = 0; i < depth; i++) begin
      acc = (acc * c_reg + 64'h8000) >> 16;
    end
    acc = (acc + 64'h8000) >> 16;
    return acc < 2 ? 2 : int'(acc);
  endfunction

  // insert with compaction; only checks room when commit is clear
  function automatic bit sketch_insert(logic [VBITS-1:0] v, bit commit);
    int unsigned fill [LEVELS];
    int unsigned h, n, first, kept, pos, na, a, b, o;
    logic [SEED_W-1:0] s;
    logic [VBITS-1:0] keep_buf [CAPACITY];
    logic [VBITS-1:0] join_buf [2*CAPACITY];
    fill = lvl_fill;
    h = lvl_top;
    s = coin;
    if (fill[0] >= CAPACITY) return 1'b0;
    if (commit) begin
      pos = 0;
      while (pos < fill[0] && lvl_mem[pos] <= v) pos++;
      for (int i = fill[0]; i > pos; i--) lvl_mem[i] = lvl_mem[i-1];
      lvl_mem[pos] = v;
    end
    fill[0]++;
    for (int l = 0; l <= h; l++) begin
      n = fill[l];
      if (n < cap_at(h - l)) break;
      s = {1'b0, s[SEED_W-1:1]} ^ (s[0] ? 32'h8020_0003 : 32'h0);
      first = s[31];
      kept = (n + 1 - first) / 2;
      if (l + 1 > h && h + 1 >= LEVELS) return 1'b0;
      if (l + 1 <= h && fill[l+1] + kept > CAPACITY) return 1'b0;
      if (commit) begin
        for (int i = 0; i < kept; i++) keep_buf[i] = lvl_mem[l*CAPACITY + first + 2*i];
        if (l + 1 > h) begin
          for (int i = 0; i < kept; i++) lvl_mem[(l+1)*CAPACITY + i] = keep_buf[i];
        end else begin
          na = fill[l+1]; a = 0; b = 0; o = 0;
          while (a < na || b < kept) begin
            if (b >= kept || (a < na && lvl_mem[(l+1)*CAPACITY + a] <= keep_buf[b])) begin
              join_buf[o] = lvl_mem[(l+1)*CAPACITY + a]; a++;
            end else begin
              join_buf[o] = keep_buf[b]; b++;
            end
            o++;
          end
          for (int i = 0; i < o; i++) lvl_mem[(l+1)*CAPACITY + i] = join_buf[i];
        end
      end
      fill[l] = 0;
      if (l + 1 > h) begin
        h++;
        fill[h] = kept;
      end else begin
        fill[l+1] += kept;
      end
    end
    if (commit) begin
      lvl_fill = fill;
      lvl_top = h;
      coin = s;
    end
    return 1'b1;
  endfunction

  // weighted count of stored entries below x
  function automatic logic [63:0] rank_below(logic [63:0] x);
    logic [63:0] total, cnt;
    total = 0;
    for (int l = 0; l <= lvl_top && l < LEVELS; l++) begin
      cnt = 0;
      for (int j = 0; j < lvl_fill[l] && j < CAPACITY; j++) begin
        if (64'(lvl_mem[l*CAPACITY + j]) < x) cnt++;
      end
      total += cnt << l;
    end
    return total;
  endfunction

  // binary search over 0..max_seen for the target rank
  function automatic logic [63:0] quantile_at(logic [Q_W-1:0] q);
    logic [63:0] u, target, lo, hi, x, r;
    int unsigned k, passes;
    u = 64'(max_seen);
    if (u == 0) return 0;
    k = 0;
    while (k < 62 && (u >> (k + 1)) != 0) k++;
    passes = k + 1 + (((u << (63 - k)) >= SQRT2_MANT) ? 1 : 0);
    target = (64'(n_items) * q + 64'h8000) >> 16;
    lo = 0; hi = u; x = hi / 2; r = 0;
    for (int i = 0; i < passes; i++) begin
      if (target == r) return x;
      r = rank_below(x);
      if (r > target) hi = x;
      else lo = x;
      x = (lo + hi) / 2;
    end
    return x;
  endfunction

  function automatic sketch_result_t predict_word(logic [OP_W-1:0] o, logic [VBITS-1:0] v,
                                                  logic [Q_W-1:0] q);
    sketch_result_t res;
    res = '0;
    case (o)
      OP_INSERT: begin
        if (is_full || !sketch_insert(v, 1'b0)) begin
          is_full = 1'b1;
          res.status = 1'b1;
        end else begin
          void'(sketch_insert(v, 1'b1));
          n_items = n_items + 1;
          if (v > max_seen) max_seen = v;
        end
      end
      OP_RANK:     res.answer = rank_below(64'(v));
      OP_QUANTILE: res.answer = quantile_at(q);
      default:     res = '0;
    endcase
    return res;
  endfunction

  // send one word, predict it on acceptance
  task automatic send_word(logic [OP_W-1:0] o, logic [VBITS-1:0] v, logic [Q_W-1:0] q);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    value <= v;
    fraction <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q = {expected_q, predict_word(o, v, q)};
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // register write, only called while drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TOP_CAPACITY:  k_reg = data[TOPCAP_W-1:0];
      CFG_SHRINK_FACTOR: c_reg = data[Q_W-1:0];
      CFG_COIN_SEED:     coin = (data != 0) ? data : 32'd1;
      default: ;
    endcase
  endtask

  function automatic logic [VBITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return VBITS'($urandom_range(0, 15));
      default: return VBITS'($urandom);
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int d;
    d = $urandom_range(0, 99);
    if (d < 60) return OP_INSERT;
    if (d < 80) return OP_RANK;
    if (d < 95) return OP_QUANTILE;
    return OP_UNUSED;
  endfunction

  // empty sketch, extremes, duplicates, unused op
  task automatic test_directed;
    send_word(OP_RANK, '0, '0);
    send_word(OP_QUANTILE, '0, 16'hFFFF);
    send_word(OP_UNUSED, '1, 16'hFFFF);
    send_word(OP_INSERT, '0, '0);
    send_word(OP_QUANTILE, '1, 16'h8000);
    send_word(OP_INSERT, '1, '1);
    send_word(OP_INSERT, 31'd5, '0);
    send_word(OP_INSERT, 31'd5, '0);
    send_word(OP_INSERT, 31'd5, '0);
    send_word(OP_INSERT, 31'd1, '0);
    send_word(OP_RANK, 31'd5, '0);
    send_word(OP_RANK, 31'd6, '0);
    send_word(OP_RANK, '1, '0);
    send_word(OP_RANK, '0, '0);
    send_word(OP_QUANTILE, '0, '0);
    send_word(OP_QUANTILE, '0, 16'h8000);
    send_word(OP_QUANTILE, '0, 16'hFFFF);
    send_word(OP_QUANTILE, '0, 16'h0001);
    send_word(OP_UNUSED, '0, '0);
    drain();
  endtask

  // out-of-range and zero register values
  task automatic test_config_edges;
    write_reg(CFG_TOP_CAPACITY, 32'd0);
    write_reg(CFG_SHRINK_FACTOR, 32'd0);
    write_reg(CFG_COIN_SEED, 32'd0);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    repeat (20) send_word(pick_op(), pick_value(), 16'($urandom));
    drain();
    write_reg(CFG_TOP_CAPACITY, 32'hFFFF_FFFF);
    write_reg(CFG_SHRINK_FACTOR, 32'h0000_FFFF);
    write_reg(CFG_COIN_SEED, 32'hFFFF_FFFF);
    repeat (20) send_word(pick_op(), pick_value(), 16'($urandom));
    drain();
  endtask

  // random phases, each under its own register setting
  task automatic test_random;
    int k;
    for (int ph = 0; ph < 6; ph++) begin
      k = (ph == 5) ? 256 : $urandom_range(2, 32);
      no_idle = (ph == 2);
      write_reg(CFG_TOP_CAPACITY, ($urandom & ~32'h1FF) | k);
      write_reg(CFG_SHRINK_FACTOR, ($urandom & ~32'hFFFF) | $urandom_range(32768, 65535));
      write_reg(CFG_COIN_SEED, $urandom | 32'd1);
      for (int i = 0; i < 150; i++) begin
        send_word(pick_op(), pick_value(), 16'($urandom));
        // hold off until every result is back
        if (i == 75) drain();
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  // fill the sketch until inserts are refused
  task automatic test_full;
    int extra;
    write_reg(CFG_TOP_CAPACITY, 32'd256);
    write_reg(CFG_SHRINK_FACTOR, 32'd65000);
    extra = 0;
    for (int i = 0; i < 1400 && extra < 8; i++) begin
      if (is_full) extra++;
      send_word(($urandom_range(0, 19) == 0) ? OP_RANK : OP_INSERT, pick_value(), '0);
    end
    send_word(OP_QUANTILE, '0, 16'($urandom));
    send_word(OP_QUANTILE, '0, 16'hFFFF);
    send_word(OP_RANK, '1, '0);
    drain();
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, actual answer %0d status %0d", $time, answer, status);
        errors++;
      end else begin
        sketch_result_t e;
        e = expected_q.pop_front();
        if (answer !== e.answer) begin
          $display("%0t: answer mismatch, expected %0d actual %0d", $time, e.answer, answer);
          errors++;
        end
        if (status !== e.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time, e.status, status);
          errors++;
        end
      end
    end
  end

  // output stall per result word
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
    end else if (out_valid && !out_stall) begin
      int n;
      n = no_idle ? 0 : $urandom_range(0, 5);
      hold_cnt <= n;
      out_stall <= (n != 0);
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= (hold_cnt > 1);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    no_idle = 1'b0;
    for (int i = 0; i < LEVELS; i++) lvl_fill[i] = 0;
    lvl_top = 0;
    n_items = '0;
    max_seen = '0;
    is_full = 1'b0;
    k_reg = RST_TOP_CAPACITY;
    c_reg = RST_SHRINK_FACTOR;
    coin = RST_COIN_SEED;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_edges();
    test_random();
    test_full();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
